// File: hw/rtl/audio_presentation_clock_assert.svh
`ifndef AUDIO_PRESENTATION_CLOCK_ASSERT_SVH
`define AUDIO_PRESENTATION_CLOCK_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define APC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("apc check failed");

// Checks a property on every clock edge, reset included.
`define APC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("apc check failed");

`endif

// File: hw/rtl/apc_pkg.sv
package apc_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned UND_W = 32;
  localparam int unsigned IN_DATA_W = 192;
  localparam int unsigned OUT_DATA_W = 232;

  localparam logic [16:0] PTS_HZ = 17'd90000;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam logic [19:0] RATE_RESET = 20'd48000;

  typedef enum logic [2:0] {
    MODE_CLOSED   = 3'd0,
    MODE_PREBUF   = 3'd1,
    MODE_PLAYING  = 3'd2,
    MODE_PAUSED   = 3'd3,
    MODE_DRAINING = 3'd4,
    MODE_STOPPED  = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    OP_QUEUE    = 4'd0,
    OP_PLAY     = 4'd1,
    OP_PAUSE    = 4'd2,
    OP_RESUME   = 4'd3,
    OP_DRAIN    = 4'd4,
    OP_COMPLETE = 4'd5,
    OP_START    = 4'd6,
    OP_UPDATE   = 4'd7,
    OP_UNDERRUN = 4'd8,
    OP_RETRACT  = 4'd9,
    OP_STOP     = 4'd10,
    OP_CLOSE    = 4'd11,
    OP_PREPARE  = 4'd12,
    OP_QUERY    = 4'd13
  } op_t;

  localparam logic REG_RATE = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: hw/rtl/apc_div.sv
module apc_div (
  input  logic              clk,
  input  logic              rst,
  input  apc_pkg::div_req_t req,
  output apc_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [5:0]                   cnt;
  logic [apc_pkg::WORD_W-1:0]   num;
  logic [apc_pkg::WORD_W-1:0]   den;
  logic [apc_pkg::WORD_W-1:0]   rem;
  logic [apc_pkg::WORD_W:0]     rem_sh;
  logic                         fits;

  assign rem_sh = {rem, num[apc_pkg::WORD_W-1]};
  assign fits = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !req.start && busy && cnt == 6'd63;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        num <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        rem <= fits ? rem_sh[apc_pkg::WORD_W-1:0] - den : rem_sh[apc_pkg::WORD_W-1:0];
        num <= {num[apc_pkg::WORD_W-2:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = num;
  assign rsp.rem = rem;

endmodule

// File: hw/rtl/audio_presentation_clock.sv
// Channel   Direction  Content
// s_axis    in         tuser: operation; tdata: frame_count, played_count, now_us, base_pts
// m_axis    out        tdata: ok, mode, drained, queued_now, underrun_total, played_pts,
//                      presented_pts
// cfg       in         cfg_index 0 frame_rate, 1 queue_limit
// One request at a time; the 64-step shared divider sets the latency.
// A request runs two conversions of two divisions each on the divider; complete adds a clamp
// step, an update that advances adds two divisions more, and with a zero frame rate the
// conversions skip the divider.
// Reset clears the mode, counters and result valid; the frame rate returns to 48000.
// A new request is taken while a result waits; finishing the next one waits for it.
module audio_presentation_clock (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // operation
  input  logic [3:0]                         s_axis_tuser,
  // frame_count, played_count, now_us, base_pts
  input  logic [apc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ok, mode, drained, queued_now, underrun_total, played_pts, presented_pts, zero fill
  output logic [apc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [apc_pkg::LIMIT_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CLAMP, S_UDIV1, S_UMUL, S_UDIV2, S_USUM, S_UCLAMP,
    S_CVT, S_CDIV1, S_CMUL, S_CDIV2, S_OUT
  } state_t;

  localparam logic [63:0] ALL_ONES = '1;

  state_t state;
  apc_pkg::div_req_t div_req;
  apc_pkg::div_rsp_t div_rsp;

  logic [19:0] frame_rate;
  logic [31:0] queue_limit;
  apc_pkg::mode_t play_mode;
  logic [63:0] submitted_total, queued_total, played_total, discarded_total;
  logic [63:0] present_position, last_time_us;
  logic [19:0] present_remainder;
  logic        present_active;
  logic [31:0] underrun_counter;

  apc_pkg::op_t op;
  logic [31:0] frames, played;
  logic [63:0] now, origin;
  logic        ok;
  logic        guard_ok;

  logic [63:0] wq, advance, prod, played_pts;
  logic [19:0] wr;
  logic        phase;

  logic [63:0] hz, pmax, adv_sum;
  logic [64:0] adv_wide, sec_prod;
  logic [40:0] scaled;
  logic [36:0] frac;
  logic [63:0] cvt_src;

  assign hz = submitted_total >= discarded_total ? submitted_total - discarded_total : '0;
  assign pmax = present_position < played_total ? played_total : present_position;
  assign sec_prod = {20'd0, wq[44:0]} * {45'd0, frame_rate};
  assign scaled = {1'b0, {20'd0, wr} * {20'd0, frame_rate}} + {21'd0, present_remainder};
  assign adv_wide = {1'b0, advance} + {1'b0, div_rsp.quo};
  assign adv_sum = adv_wide[64] ? ALL_ONES : adv_wide[63:0];
  assign frac = {17'd0, wr} * {20'd0, apc_pkg::PTS_HZ};
  assign cvt_src = phase ? present_position : played_total;

  assign s_axis_tready = state == S_IDLE;

  always_comb begin
    unique case (op)
      apc_pkg::OP_QUEUE: begin
        guard_ok = frames != '0 && (play_mode == apc_pkg::MODE_PREBUF ||
                   play_mode == apc_pkg::MODE_PLAYING || play_mode == apc_pkg::MODE_PAUSED) &&
                   (queue_limit == '0 || (frames <= queue_limit &&
                   queued_total <= {32'd0, queue_limit - frames}));
      end
      apc_pkg::OP_PLAY: begin
        guard_ok = play_mode == apc_pkg::MODE_PREBUF && queued_total != '0;
      end
      apc_pkg::OP_PAUSE: begin
        guard_ok = play_mode == apc_pkg::MODE_PLAYING;
      end
      apc_pkg::OP_RESUME: begin
        guard_ok = play_mode == apc_pkg::MODE_PAUSED;
      end
      apc_pkg::OP_DRAIN: begin
        guard_ok = play_mode == apc_pkg::MODE_PLAYING || play_mode == apc_pkg::MODE_PREBUF;
      end
      apc_pkg::OP_COMPLETE: begin
        guard_ok = frames != '0 && played <= frames && queued_total >= {32'd0, frames} &&
                   (play_mode == apc_pkg::MODE_PLAYING ||
                   play_mode == apc_pkg::MODE_DRAINING);
      end
      apc_pkg::OP_START: begin
        guard_ok = play_mode == apc_pkg::MODE_PLAYING;
      end
      apc_pkg::OP_UPDATE: begin
        guard_ok = present_active && (play_mode == apc_pkg::MODE_PLAYING ||
                   play_mode == apc_pkg::MODE_DRAINING);
      end
      apc_pkg::OP_UNDERRUN: begin
        guard_ok = play_mode == apc_pkg::MODE_PLAYING;
      end
      apc_pkg::OP_RETRACT: begin
        guard_ok = underrun_counter != '0;
      end
      apc_pkg::OP_STOP: begin
        guard_ok = play_mode != apc_pkg::MODE_CLOSED;
      end
      apc_pkg::OP_CLOSE: begin
        guard_ok = 1'b1;
      end
      apc_pkg::OP_PREPARE: begin
        guard_ok = 1'b1;
      end
      apc_pkg::OP_QUERY: begin
        guard_ok = 1'b1;
      end
      default: begin
        guard_ok = 1'b0;
      end
    endcase
  end

  apc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      frame_rate <= apc_pkg::RATE_RESET;
      queue_limit <= '0;
      play_mode <= apc_pkg::MODE_CLOSED;
      submitted_total <= '0;
      queued_total <= '0;
      played_total <= '0;
      discarded_total <= '0;
      present_position <= '0;
      present_remainder <= '0;
      last_time_us <= '0;
      present_active <= 1'b0;
      underrun_counter <= '0;
      m_axis_tvalid <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == apc_pkg::REG_RATE) begin
          frame_rate <= cfg_data[19:0];
        end else begin
          queue_limit <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op <= apc_pkg::op_t'(s_axis_tuser);
            frames <= s_axis_tdata[31:0];
            played <= s_axis_tdata[63:32];
            now <= s_axis_tdata[127:64];
            origin <= s_axis_tdata[191:128];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          ok <= guard_ok;
          phase <= 1'b0;
          if (guard_ok && op == apc_pkg::OP_COMPLETE) begin
            state <= S_CLAMP;
          end else if (guard_ok && op == apc_pkg::OP_UPDATE && now > last_time_us) begin
            state <= S_UDIV1;
          end else begin
            state <= S_CVT;
          end
          if (guard_ok) begin
            unique case (op)
              apc_pkg::OP_QUEUE: begin
                submitted_total <= submitted_total + {32'd0, frames};
                queued_total <= queued_total + {32'd0, frames};
              end
              apc_pkg::OP_PLAY: begin
                play_mode <= apc_pkg::MODE_PLAYING;
              end
              apc_pkg::OP_PAUSE: begin
                present_active <= 1'b0;
                play_mode <= apc_pkg::MODE_PAUSED;
              end
              apc_pkg::OP_RESUME: begin
                play_mode <= apc_pkg::MODE_PLAYING;
              end
              apc_pkg::OP_DRAIN: begin
                play_mode <= apc_pkg::MODE_DRAINING;
              end
              apc_pkg::OP_COMPLETE: begin
                queued_total <= queued_total - {32'd0, frames};
                played_total <= played_total + {32'd0, played};
                discarded_total <= discarded_total + {32'd0, frames - played};
              end
              apc_pkg::OP_START: begin
                present_position <= pmax;
                last_time_us <= now;
                present_remainder <= '0;
                present_active <= 1'b1;
              end
              apc_pkg::OP_UPDATE: begin
                last_time_us <= now;
                if (now > last_time_us) begin
                  div_req.start <= 1'b1;
                  div_req.num <= now - last_time_us;
                  div_req.den <= {44'd0, apc_pkg::US_PER_SEC};
                end
              end
              apc_pkg::OP_UNDERRUN: begin
                underrun_counter <= underrun_counter + 32'd1;
              end
              apc_pkg::OP_RETRACT: begin
                underrun_counter <= underrun_counter - 32'd1;
              end
              apc_pkg::OP_STOP: begin
                discarded_total <= discarded_total + queued_total;
                queued_total <= '0;
                present_active <= 1'b0;
                play_mode <= apc_pkg::MODE_STOPPED;
              end
              apc_pkg::OP_CLOSE: begin
                if (play_mode != apc_pkg::MODE_CLOSED) begin
                  discarded_total <= discarded_total + queued_total;
                  queued_total <= '0;
                  present_active <= 1'b0;
                end
                play_mode <= apc_pkg::MODE_CLOSED;
              end
              apc_pkg::OP_PREPARE: begin
                submitted_total <= '0;
                queued_total <= '0;
                played_total <= '0;
                discarded_total <= '0;
                present_position <= '0;
                present_remainder <= '0;
                last_time_us <= '0;
                present_active <= 1'b0;
                underrun_counter <= '0;
                play_mode <= frame_rate == '0 ? apc_pkg::MODE_CLOSED : apc_pkg::MODE_PREBUF;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLAMP: begin
          if (pmax > hz) begin
            present_position <= hz;
            present_remainder <= '0;
          end else begin
            present_position <= pmax;
          end
          state <= S_CVT;
        end
        S_UDIV1: begin
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            wq <= div_rsp.quo;
            wr <= div_rsp.rem[19:0];
            state <= S_UMUL;
          end
        end
        S_UMUL: begin
          advance <= sec_prod[64] ? ALL_ONES : sec_prod[63:0];
          div_req.start <= 1'b1;
          div_req.num <= {23'd0, scaled};
          div_req.den <= {44'd0, apc_pkg::US_PER_SEC};
          state <= S_UDIV2;
        end
        S_UDIV2: begin
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            advance <= adv_sum;
            wr <= div_rsp.rem[19:0];
            state <= S_UCLAMP;
          end
        end
        S_UCLAMP: begin
          if (pmax >= hz || advance >= hz - pmax) begin
            present_position <= hz;
            present_remainder <= '0;
          end else begin
            present_position <= pmax + advance;
            present_remainder <= wr;
          end
          state <= S_CVT;
        end
        S_CVT: begin
          if (frame_rate == '0) begin
            if (phase) begin
              state <= S_OUT;
            end else begin
              played_pts <= origin;
              phase <= 1'b1;
            end
          end else begin
            div_req.start <= 1'b1;
            div_req.num <= cvt_src;
            div_req.den <= {44'd0, frame_rate};
            state <= S_CDIV1;
          end
        end
        S_CDIV1: begin
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            wq <= div_rsp.quo;
            wr <= div_rsp.rem[19:0];
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          prod <= origin + wq * {47'd0, apc_pkg::PTS_HZ};
          div_req.start <= 1'b1;
          div_req.num <= {27'd0, frac};
          div_req.den <= {44'd0, frame_rate};
          state <= S_CDIV2;
        end
        S_CDIV2: begin
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            if (phase) begin
              prod <= prod + div_rsp.quo;
              state <= S_OUT;
            end else begin
              played_pts <= prod + div_rsp.quo;
              phase <= 1'b1;
              state <= S_CVT;
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {3'd0, frame_rate == '0 ? origin : prod, played_pts,
                             underrun_counter, queued_total,
                             play_mode == apc_pkg::MODE_DRAINING && queued_total == '0,
                             play_mode, ok};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/apc_check.sv
module apc_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [apc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

`include "audio_presentation_clock_assert.svh"

  `APC_ASSERT(out_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `APC_ASSERT(busy_after_request, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `APC_ASSERT(drained_only_draining, m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:1] == apc_pkg::MODE_DRAINING)
  `APC_ASSERT_ALWAYS(reset_clears_out, rst |=> !m_axis_tvalid)

endmodule

bind audio_presentation_clock apc_check u_apc_check (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
